>>> rtl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the sliding window rate limiter
// Holds the time constants, the register index codes and the request and
// response bundles of the serial multiply-divide unit.
// ----------------------------------------------------------------------------
package swrl_pkg;

	// Time constants in nanoseconds.
	localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [63:0] NS_PER_MS  = 64'd1000000;

	// Width of a clamped window in ns (40 s fits in 36 bits).
	localparam int WIN_W = 36;
	localparam logic [WIN_W-1:0] WIN_LOW  = 36'd100000000;
	localparam logic [WIN_W-1:0] WIN_HIGH = 36'd40000000000;

	// Saturation value of rates and delays.
	localparam logic [30:0] INT_SAT = 31'h7FFFFFFF;

	// Register defaults applied when a setting is out of range.
	localparam logic [30:0] MIN_WIN_FLOOR   = 31'd40000;
	localparam logic [30:0] MIN_WIN_DEFAULT = 31'd1000;
	localparam logic [31:0] MAX_WIN_PAD     = 32'd4000;
	localparam logic [30:0] DELAY_DEFAULT   = 31'd1000;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MIN_WINDOW  = 3'd0;
	localparam logic [2:0] CFG_MAX_WINDOW  = 3'd1;
	localparam logic [2:0] CFG_MAX_AMOUNT  = 3'd2;
	localparam logic [2:0] CFG_MAX_OPS     = 3'd3;
	localparam logic [2:0] CFG_MAX_DELAY   = 3'd4;

	// Request to the multiply-divide unit: q = (a * b) / d.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} md_req_t;

	// Response of the multiply-divide unit.
	typedef struct packed {
		logic        done;
		logic        busy;
		logic [63:0] q;
	} md_rsp_t;

endpackage

>>> rtl/swrl_muldiv.sv
// ----------------------------------------------------------------------------
// swrl_muldiv: bit-serial multiply then divide
// Forms the exact 128-bit product a * b one bit per cycle, then divides it
// by d with a restoring divider one bit per cycle.
// A quotient that does not fit in 64 bits saturates to all ones.
// ----------------------------------------------------------------------------
module swrl_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  swrl_pkg::md_req_t  req,
	output swrl_pkg::md_rsp_t  rsp
);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t    state_q;
	logic [6:0]   cnt_q;
	logic         done_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  d_q;
	logic [127:0] prod_q;
	logic [63:0]  rem_q;

	logic [64:0]  mul_sum;
	logic [64:0]  div_shift;
	logic [64:0]  div_diff;
	logic         div_ge;

	// One shift-add step and one restoring divide step.
	always_comb begin
		mul_sum   = {1'b0, prod_q[127:64]} + (b_q[0] ? {1'b0, a_q} : 65'd0);
		div_shift = {rem_q, prod_q[127]};
		div_ge    = div_shift >= {1'b0, d_q};
		div_diff  = div_shift - {1'b0, d_q};
	end

	// Sequencing of the two phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= 7'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						cnt_q   <= 7'd0;
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						cnt_q   <= 7'd0;
						state_q <= MD_DIV;
					end
				end
				MD_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q    <= req.a;
					b_q    <= req.b;
					d_q    <= req.d;
					prod_q <= 128'd0;
				end
			end
			MD_MUL: begin
				prod_q <= {mul_sum, prod_q[63:1]};
				b_q    <= {1'b0, b_q[63:1]};
				rem_q  <= 64'd0;
			end
			MD_DIV: begin
				rem_q  <= div_ge ? div_diff[63:0] : div_shift[63:0];
				prod_q <= {prod_q[126:0], div_ge};
			end
			default: rem_q <= 64'd0;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.busy = (state_q != MD_IDLE);
	assign rsp.q    = (|prod_q[127:64]) ? {64{1'b1}} : prod_q[63:0];

endmodule

>>> rtl/sliding_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter: one item at a time; each item needs 3 to 7
// runs of the shared bit-serial multiply-divide unit.
// Reset (arst_n low, asynchronous) clears registers, window and totals.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [62:0] now_ns,
	input  logic signed [31:0] amount,
	// Output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] delay_ms,
	output logic [11:0] sleep_ms,
	output logic [30:0] amount_rate,
	output logic [30:0] ops_rate,
	output logic [63:0] total_amount,
	output logic [63:0] total_ops
);

	localparam int WW = swrl_pkg::WIN_W;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_WIN     = 18'h00002,
		S_MAXNS   = 18'h00004,
		S_CHECK   = 18'h00008,
		S_DEC_A   = 18'h00010,
		S_DEC_O   = 18'h00020,
		S_MOVE    = 18'h00040,
		S_REWIN   = 18'h00080,
		S_ADD     = 18'h00100,
		S_RATE_A  = 18'h00200,
		S_RATE_O  = 18'h00400,
		S_OVA_CHK = 18'h00800,
		S_OVS_A   = 18'h01000,
		S_OVO_CHK = 18'h02000,
		S_OVS_O   = 18'h04000,
		S_DMS_GO  = 18'h08000,
		S_DMS     = 18'h10000,
		S_FIN     = 18'h20000
	} state_t;

	state_t              state_q;
	swrl_pkg::md_req_t   md_req_q;
	swrl_pkg::md_rsp_t   md_rsp;

	// Configuration registers
	logic [30:0] min_win_q, max_win_q, max_arate_q, max_orate_q, max_delay_q;

	// Limiter state
	logic [63:0] stamp_q, acc_a_q, acc_o_q, tot_a_q, tot_o_q;

	// Per-item work registers
	logic [62:0]   now_q;
	logic [30:0]   amt_q;
	logic [WW-1:0] window_q;
	logic [WW-1:0] excess_q;
	logic [51:0]   min_ns_q;
	logic [51:0]   max_ns_q;
	logic          moved_q;
	logic [30:0]   arate_q, orate_q, delay_q;
	logic [11:0]   dms_q;

	// Output registers
	logic        out_valid_q;
	logic [11:0] delay_ms_q, sleep_ms_q;
	logic [30:0] amount_rate_q, ops_rate_q;
	logic [63:0] total_amount_q, total_ops_q;

	// Combinational helpers
	logic [30:0]   amt_in;
	logic [30:0]   min_eff;
	logic [31:0]   max_eff;
	logic [51:0]   min_ns_calc;
	logic [51:0]   max_ns_calc;
	logic [WW-1:0] win_calc;
	logic [WW-1:0] excess_calc;
	logic [64:0]   acc_a_sum;
	logic [63:0]   acc_a_next;
	logic [63:0]   ovs_diff;
	logic [30:0]   ovs_sat;
	logic [30:0]   rate_sat;
	logic [30:0]   delay_cap;
	logic [11:0]   sleep_calc;
	logic          in_xfer;

	// Window length clamped to 0.1 s .. 40 s; a stamp ahead of now gives 0.1 s.
	function automatic logic [WW-1:0] clamp_win(input logic [62:0] now,
	                                            input logic [63:0] stamp);
		logic [63:0] w;
		logic [WW-1:0] r;
		w = {1'b0, now} - stamp;
		priority if (stamp > {1'b0, now}) begin
			r = swrl_pkg::WIN_LOW;
		end else if (w < {{(64-WW){1'b0}}, swrl_pkg::WIN_LOW}) begin
			r = swrl_pkg::WIN_LOW;
		end else if (w > {{(64-WW){1'b0}}, swrl_pkg::WIN_HIGH}) begin
			r = swrl_pkg::WIN_HIGH;
		end else begin
			r = w[WW-1:0];
		end
		return r;
	endfunction

	always_comb begin
		amt_in      = amount[31] ? 31'd0 : amount[30:0];
		min_eff     = (min_win_q <= swrl_pkg::MIN_WIN_FLOOR) ?
		              swrl_pkg::MIN_WIN_DEFAULT : min_win_q;
		max_eff     = (max_win_q <= min_eff) ? ({1'b0, min_eff} + swrl_pkg::MAX_WIN_PAD) :
		              {1'b0, max_win_q};
		min_ns_calc = {21'd0, min_eff} * swrl_pkg::NS_PER_MS[51:0];
		max_ns_calc = {20'd0, max_eff} * swrl_pkg::NS_PER_MS[51:0];
		win_calc    = clamp_win(now_q, stamp_q);
		excess_calc = window_q - min_ns_q[WW-1:0];
		acc_a_sum   = {1'b0, acc_a_q} + {34'd0, amt_q};
		acc_a_next  = (amt_q == 31'd0) ? acc_a_q :
		              (acc_a_sum[64] ? {64{1'b1}} : acc_a_sum[63:0]);
		ovs_diff    = md_rsp.q - {{(64-WW){1'b0}}, window_q};
		ovs_sat     = (ovs_diff > {33'd0, swrl_pkg::INT_SAT}) ? swrl_pkg::INT_SAT :
		              ovs_diff[30:0];
		rate_sat    = (md_rsp.q > {33'd0, swrl_pkg::INT_SAT}) ? swrl_pkg::INT_SAT :
		              md_rsp.q[30:0];
		delay_cap   = (max_delay_q == 31'd0) ? swrl_pkg::DELAY_DEFAULT : max_delay_q;
		if (dms_q == 12'd0) begin
			sleep_calc = 12'd0;
		end else if ({19'd0, dms_q} > delay_cap) begin
			sleep_calc = delay_cap[11:0];
		end else begin
			sleep_calc = dms_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_win_q   <= 31'd0;
			max_win_q   <= 31'd0;
			max_arate_q <= 31'd0;
			max_orate_q <= 31'd0;
			max_delay_q <= 31'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swrl_pkg::CFG_MIN_WINDOW: min_win_q   <= cfg_wdata;
				swrl_pkg::CFG_MAX_WINDOW: max_win_q   <= cfg_wdata;
				swrl_pkg::CFG_MAX_AMOUNT: max_arate_q <= cfg_wdata;
				swrl_pkg::CFG_MAX_OPS:    max_orate_q <= cfg_wdata;
				swrl_pkg::CFG_MAX_DELAY:  max_delay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer: window bookkeeping, decay, rates, overshoot and delay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			md_req_q       <= '0;
			stamp_q        <= 64'd0;
			acc_a_q        <= 64'd0;
			acc_o_q        <= 64'd0;
			tot_a_q        <= 64'd0;
			tot_o_q        <= 64'd0;
			now_q          <= 63'd0;
			amt_q          <= 31'd0;
			window_q       <= '0;
			excess_q       <= '0;
			min_ns_q       <= 52'd0;
			max_ns_q       <= 52'd0;
			moved_q        <= 1'b0;
			arate_q        <= 31'd0;
			orate_q        <= 31'd0;
			delay_q        <= 31'd0;
			dms_q          <= 12'd0;
			out_valid_q    <= 1'b0;
			delay_ms_q     <= 12'd0;
			sleep_ms_q     <= 12'd0;
			amount_rate_q  <= 31'd0;
			ops_rate_q     <= 31'd0;
			total_amount_q <= 64'd0;
			total_ops_q    <= 64'd0;
		end else begin
			md_req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						now_q <= now_ns;
						amt_q <= kind ? 31'd0 : amt_in;
						if (kind) begin
							stamp_q <= 64'd0;
						end
						if (!kind && amt_in != 31'd0) begin
							tot_a_q <= tot_a_q + {33'd0, amt_in};
							tot_o_q <= tot_o_q + 64'd1;
						end
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					window_q <= win_calc;
					min_ns_q <= min_ns_calc;
					state_q  <= S_MAXNS;
				end
				S_MAXNS: begin
					max_ns_q <= max_ns_calc;
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					moved_q <= 1'b0;
					if (stamp_q < swrl_pkg::NS_PER_SEC ||
					    {{(52-WW){1'b0}}, window_q} > max_ns_q) begin
						// Unset or stale window: start a fresh count.
						stamp_q  <= {1'b0, now_q};
						acc_a_q  <= 64'd0;
						acc_o_q  <= 64'd0;
						window_q <= swrl_pkg::WIN_LOW;
						state_q  <= S_ADD;
					end else if ({{(53-WW){1'b0}}, window_q} > {min_ns_q, 1'b0}) begin
						// Long window: remove the share of the excess time.
						excess_q       <= excess_calc;
						md_req_q.start <= 1'b1;
						md_req_q.a     <= acc_a_q;
						md_req_q.b     <= {{(64-WW){1'b0}}, excess_calc};
						md_req_q.d     <= {{(64-WW){1'b0}}, window_q};
						state_q        <= S_DEC_A;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_DEC_A: begin
					if (md_rsp.done) begin
						if (md_rsp.q != 64'd0) begin
							acc_a_q <= acc_a_q - md_rsp.q;
							moved_q <= 1'b1;
						end
						md_req_q.start <= 1'b1;
						md_req_q.a     <= acc_o_q;
						md_req_q.b     <= {{(64-WW){1'b0}}, excess_q};
						md_req_q.d     <= {{(64-WW){1'b0}}, window_q};
						state_q        <= S_DEC_O;
					end
				end
				S_DEC_O: begin
					if (md_rsp.done) begin
						if (md_rsp.q != 64'd0) begin
							acc_o_q <= acc_o_q - md_rsp.q;
						end
						if (moved_q || md_rsp.q != 64'd0) begin
							state_q <= S_MOVE;
						end else begin
							state_q <= S_ADD;
						end
					end
				end
				S_MOVE: begin
					stamp_q <= stamp_q + {{(64-WW){1'b0}}, excess_q};
					state_q <= S_REWIN;
				end
				S_REWIN: begin
					window_q <= win_calc;
					state_q  <= S_ADD;
				end
				S_ADD: begin
					// Account this event, then start the amount rate.
					if (amt_q != 31'd0) begin
						acc_a_q <= acc_a_next;
						if (acc_o_q != {64{1'b1}}) begin
							acc_o_q <= acc_o_q + 64'd1;
						end
					end
					md_req_q.start <= 1'b1;
					md_req_q.a     <= acc_a_next;
					md_req_q.b     <= swrl_pkg::NS_PER_SEC;
					md_req_q.d     <= {{(64-WW){1'b0}}, window_q};
					state_q        <= S_RATE_A;
				end
				S_RATE_A: begin
					if (md_rsp.done) begin
						arate_q        <= rate_sat;
						md_req_q.start <= 1'b1;
						md_req_q.a     <= acc_o_q;
						md_req_q.b     <= swrl_pkg::NS_PER_SEC;
						md_req_q.d     <= {{(64-WW){1'b0}}, window_q};
						state_q        <= S_RATE_O;
					end
				end
				S_RATE_O: begin
					if (md_rsp.done) begin
						orate_q <= rate_sat;
						state_q <= S_OVA_CHK;
					end
				end
				S_OVA_CHK: begin
					delay_q <= 31'd0;
					if (max_arate_q != 31'd0 && arate_q > max_arate_q) begin
						md_req_q.start <= 1'b1;
						md_req_q.a     <= {{(64-WW){1'b0}}, window_q};
						md_req_q.b     <= {33'd0, arate_q};
						md_req_q.d     <= {33'd0, max_arate_q};
						state_q        <= S_OVS_A;
					end else begin
						state_q <= S_OVO_CHK;
					end
				end
				S_OVS_A: begin
					if (md_rsp.done) begin
						delay_q <= ovs_sat;
						state_q <= S_OVO_CHK;
					end
				end
				S_OVO_CHK: begin
					if (max_orate_q != 31'd0 && orate_q > max_orate_q) begin
						md_req_q.start <= 1'b1;
						md_req_q.a     <= {{(64-WW){1'b0}}, window_q};
						md_req_q.b     <= {33'd0, orate_q};
						md_req_q.d     <= {33'd0, max_orate_q};
						state_q        <= S_OVS_O;
					end else begin
						state_q <= S_DMS_GO;
					end
				end
				S_OVS_O: begin
					if (md_rsp.done) begin
						if (ovs_sat > delay_q) begin
							delay_q <= ovs_sat;
						end
						state_q <= S_DMS_GO;
					end
				end
				S_DMS_GO: begin
					// Delay in ns to ms on the same serial unit.
					md_req_q.start <= 1'b1;
					md_req_q.a     <= {33'd0, delay_q};
					md_req_q.b     <= 64'd1;
					md_req_q.d     <= swrl_pkg::NS_PER_MS;
					state_q        <= S_DMS;
				end
				S_DMS: begin
					if (md_rsp.done) begin
						dms_q   <= md_rsp.q[11:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Wait for a free output register, then load the result.
					if (!out_valid_q) begin
						out_valid_q    <= 1'b1;
						delay_ms_q     <= dms_q;
						sleep_ms_q     <= sleep_calc;
						amount_rate_q  <= arate_q;
						ops_rate_q     <= orate_q;
						total_amount_q <= tot_a_q;
						total_ops_q    <= tot_o_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	swrl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req_q),
		.rsp    (md_rsp)
	);

	assign out_valid    = out_valid_q;
	assign delay_ms     = delay_ms_q;
	assign sleep_ms     = sleep_ms_q;
	assign amount_rate  = amount_rate_q;
	assign ops_rate     = ops_rate_q;
	assign total_amount = total_amount_q;
	assign total_ops    = total_ops_q;

`ifndef ASSERT_OFF
	// A new run is never started while the serial unit is still working.
	assert property (@(posedge clk) disable iff (!arst_n)
		md_req_q.start |-> !md_rsp.busy)
		else $error("muldiv started while busy");

	// A finished run only ever lands in a state that waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == S_DEC_A || state_q == S_DEC_O ||
		                 state_q == S_RATE_A || state_q == S_RATE_O ||
		                 state_q == S_OVS_A || state_q == S_OVS_O ||
		                 state_q == S_DMS))
		else $error("muldiv result with no waiting state");

	// The delay stays in range and the capped delay never exceeds it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (delay_ms <= 12'd2147 && sleep_ms <= delay_ms))
		else $error("delay out of range");
`endif

endmodule
